FILE: rtl/cdtt_pkg.sv
// Shared types and codes for the countdown timer table.
// Holds the request/response payloads, the cell control/status structs
// and the operation, result and slot status codes. No dependencies.
package cdtt_pkg;

   // Field widths
   localparam int ACTION_W  = 3;
   localparam int SLOT_W    = 5;
   localparam int CHAN_W    = 4;
   localparam int DATA_W    = 8;
   localparam int TICKS_W   = 32;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_BIND  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_START = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd4;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

   // Slot status
   localparam logic [STATUS_W-1:0] STAT_FREE  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ALLOC = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RUN   = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   slot;
      logic [CHAN_W-1:0]   channel;
      logic [DATA_W-1:0]   event_data;
      logic [TICKS_W-1:0]  timeout;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  slot_res;
      logic               granted;
      logic [CHAN_W-1:0]  channel_res;
      logic [DATA_W-1:0]  event_data_res;
      logic [TICKS_W-1:0] tick_count;
      logic               last;
   } rsp_type;

   // Control broadcast to every cell
   typedef struct packed {
      logic adv;       // token holder acts and the token moves on
      logic shift;     // token chain moves (adv or scan launch)
      logic is_tick;   // scan is a tick, else an allocate
      logic wr_free;
      logic wr_bind;
      logic wr_start;
   } cell_ctl_type;

   // Status handed back by each cell
   typedef struct packed {
      logic              hit;   // expired or granted in this cycle
      logic              tok;   // token passed to the next cell
      logic [CHAN_W-1:0] channel;
      logic [DATA_W-1:0] event_data;
   } cell_out_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

endpackage

FILE: rtl/countdown_timer_table_core.sv
// Channel | ports                              | direction
// req     | req_valid, req_stall, req_data     | in  (req_stall driven here)
// rsp     | rsp_valid, rsp_stall, rsp_data     | out (rsp_stall driven by sink)
//
// Free, bind, start and unknown actions answer with a registered acknowledge in the cycle after they are accepted.
// Allocate and tick walk a token along the row of timer cells, one cell per
// cycle while the response register is free: a tick visits every cell and then
// answers done, an allocate ends at the first free slot or, if none, with a denial.
// Reset frees every slot and clears the tick count.
// A stalled response freezes the token walk until the response is taken.
// Depends on cdtt_pkg and cdtt_cell.
module countdown_timer_table_core #(
   parameter int NUM_TIMERS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cdtt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cdtt_pkg::rsp_type rsp_data
);

   localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   cdtt_pkg::state_type     state_ff, state_in;
   logic [IdxW-1:0]         idx_ff, idx_in;
   logic [cdtt_pkg::TICKS_W-1:0] ticks_ff, ticks_in;
   logic                    is_tick_ff, is_tick_in;
   cdtt_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   cdtt_pkg::cell_ctl_type  ctl;
   cdtt_pkg::cell_out_type  cout [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]   sel;
   logic [NUM_TIMERS-1:0]   tok_prev;

   logic                    out_free;
   logic                    req_acc;
   logic                    scan_start;
   logic                    hit_any;
   logic [cdtt_pkg::CHAN_W-1:0] hit_chan;
   logic [cdtt_pkg::DATA_W-1:0] hit_data;

   // Handshake
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall  = (state_ff != cdtt_pkg::ST_IDLE) | ~out_free;
   assign req_acc    = req_valid & ~req_stall;
   assign scan_start = req_acc & ((req_data.action == cdtt_pkg::ACT_ALLOC) |
                                  (req_data.action == cdtt_pkg::ACT_TICK));

   // Broadcast control to the cells
   always_comb begin
      ctl.adv      = (state_ff == cdtt_pkg::ST_SCAN) & out_free;
      ctl.shift    = ctl.adv | scan_start;
      ctl.is_tick  = is_tick_ff;
      ctl.wr_free  = req_acc & (req_data.action == cdtt_pkg::ACT_FREE);
      ctl.wr_bind  = req_acc & (req_data.action == cdtt_pkg::ACT_BIND);
      ctl.wr_start = req_acc & (req_data.action == cdtt_pkg::ACT_START);
   end

   // Row of cells, token enters at slot 0
   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      assign sel[i] = (32'(req_data.slot) == i);
      if (i == 0) begin : g_head
         assign tok_prev[i] = scan_start;
      end else begin : g_link
         assign tok_prev[i] = cout[i-1].tok;
      end
      cdtt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .req      (req_data),
         .sel      (sel[i]),
         .tok_prev (tok_prev[i]),
         .cout     (cout[i])
      );
   end

   // Collect the acting cell's payload; at most one cell hits
   always_comb begin
      hit_any  = 1'b0;
      hit_chan = '0;
      hit_data = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         hit_any  = hit_any | cout[i].hit;
         hit_chan = hit_chan | (cout[i].hit ? cout[i].channel : '0);
         hit_data = hit_data | (cout[i].hit ? cout[i].event_data : '0);
      end
   end

   // Sequencer and response register
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      ticks_in     = ticks_ff;
      is_tick_in   = is_tick_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      unique case (state_ff)
         cdtt_pkg::ST_IDLE: begin
            if (req_acc) begin
               unique case (req_data.action)
                  cdtt_pkg::ACT_ALLOC: begin
                     state_in   = cdtt_pkg::ST_SCAN;
                     idx_in     = '0;
                     is_tick_in = 1'b0;
                  end
                  cdtt_pkg::ACT_TICK: begin
                     state_in   = cdtt_pkg::ST_SCAN;
                     idx_in     = '0;
                     is_tick_in = 1'b1;
                     ticks_in   = ticks_ff + 1'b1;
                  end
                  default: begin
                     rsp_in       = '0;
                     rsp_in.kind  = cdtt_pkg::KIND_ACK;
                     rsp_in.last  = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         cdtt_pkg::ST_SCAN: begin
            if (ctl.adv) begin
               if (hit_any) begin
                  rsp_in          = '0;
                  rsp_in.slot_res = cdtt_pkg::SLOT_W'(idx_ff);
                  rsp_valid_in    = 1'b1;
                  if (is_tick_ff) begin
                     rsp_in.kind           = cdtt_pkg::KIND_EXPIRY;
                     rsp_in.channel_res    = hit_chan;
                     rsp_in.event_data_res = hit_data;
                     rsp_in.tick_count     = ticks_ff;
                  end else begin
                     rsp_in.kind    = cdtt_pkg::KIND_ALLOC;
                     rsp_in.granted = 1'b1;
                     rsp_in.last    = 1'b1;
                  end
               end
               // Grant ends the walk; otherwise advance or finish
               if (hit_any && !is_tick_ff) begin
                  state_in = cdtt_pkg::ST_IDLE;
               end else if (idx_ff == IdxW'(NUM_TIMERS - 1)) begin
                  state_in = cdtt_pkg::ST_FIN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         cdtt_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cdtt_pkg::ST_IDLE;
               if (is_tick_ff) begin
                  rsp_in.kind       = cdtt_pkg::KIND_DONE;
                  rsp_in.tick_count = ticks_ff;
               end else begin
                  rsp_in.kind = cdtt_pkg::KIND_ALLOC;
               end
            end
         end
         default: begin
            state_in = cdtt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdtt_pkg::ST_IDLE;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold scan position, scan kind and response payload
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      is_tick_ff <= is_tick_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/cdtt_cell.sv
// One timer cell: status, remaining count, channel and data byte of one slot.
// Acts when the scan token sits here and passes the token to its neighbor.
// Depends on cdtt_pkg.
module cdtt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  cdtt_pkg::cell_ctl_type ctl,
   input  cdtt_pkg::req_type     req,
   input  logic                  sel,
   input  logic                  tok_prev,
   output cdtt_pkg::cell_out_type cout
);

   logic [cdtt_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [cdtt_pkg::TICKS_W-1:0]  rem_ff, rem_in;
   logic [cdtt_pkg::CHAN_W-1:0]   chan_ff, chan_in;
   logic [cdtt_pkg::DATA_W-1:0]   byte_ff, byte_in;
   logic                          tok_ff, tok_in;

   logic [cdtt_pkg::TICKS_W-1:0]  rem_dec;
   logic                          act;
   logic                          running;
   logic                          tick_hit;
   logic                          grant;

   // Evaluate this slot while it holds the token
   always_comb begin
      rem_dec  = rem_ff - 1'b1;
      act      = tok_ff & ctl.adv;
      running  = (status_ff == cdtt_pkg::STAT_RUN);
      tick_hit = act & ctl.is_tick & running & (rem_dec == '0);
      grant    = act & ~ctl.is_tick & (status_ff == cdtt_pkg::STAT_FREE);
   end

   // Next state of the slot
   always_comb begin
      status_in = status_ff;
      rem_in    = rem_ff;
      chan_in   = chan_ff;
      byte_in   = byte_ff;
      tok_in    = ctl.shift ? tok_prev : tok_ff;

      if (ctl.wr_free && sel) begin
         status_in = cdtt_pkg::STAT_FREE;
      end
      if (ctl.wr_start && sel) begin
         status_in = cdtt_pkg::STAT_RUN;
         rem_in    = req.timeout;
      end
      if (ctl.wr_bind && sel) begin
         chan_in = req.channel;
         byte_in = req.event_data;
      end
      if (act && ctl.is_tick && running) begin
         rem_in = rem_dec;
      end
      if (tick_hit || grant) begin
         status_in = cdtt_pkg::STAT_ALLOC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= cdtt_pkg::STAT_FREE;
         tok_ff    <= 1'b0;
      end else begin
         status_ff <= status_in;
         tok_ff    <= tok_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      chan_ff <= chan_in;
      byte_ff <= byte_in;
   end

   // Drop the token once granted, so the scan ends here
   always_comb begin
      cout.hit        = tick_hit | grant;
      cout.tok        = tok_ff & ~grant;
      cout.channel    = chan_ff;
      cout.event_data = byte_ff;
   end

endmodule
